>>> rtl/ggrs_pkg.sv
// ----------------------------------------------------------------------------
// ggrs_pkg: shared types and constants of the greedy route search core
// Table geometry, request and status codes and the node table word layout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ggrs_pkg;

    localparam int MAX_NODES  = 64;
    localparam int MAX_DEGREE = 8;
    localparam int NODE_W     = $clog2(MAX_NODES);
    localparam int SLOT_W     = $clog2(MAX_DEGREE);
    localparam int DEG_W      = 4;
    localparam int DEPTH_W    = NODE_W + 1;
    localparam int X_W        = 11;
    localparam int Y_W        = 10;
    localparam int LM_W       = 8;
    localparam int DIST_W     = 23;
    localparam int BEST_W     = 24;
    localparam int GUARD_W    = 9;

    localparam logic [BEST_W-1:0]  FAR_DISTANCE = 24'd9000000;
    localparam logic [GUARD_W-1:0] GUARD_LIMIT  = GUARD_W'(4 * MAX_NODES + 4);
    localparam logic [DEG_W-1:0]   DEG_MAX      = DEG_W'(MAX_DEGREE);

    // request kinds
    localparam logic [1:0] REQ_NODE  = 2'd0;
    localparam logic [1:0] REQ_NBR   = 2'd1;
    localparam logic [1:0] REQ_ROUTE = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_REFUSED  = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_NOROUTE  = 2'd3;

    // config register indexes
    localparam logic [1:0] CFG_EXCL_A = 2'd0;
    localparam logic [1:0] CFG_EXCL_B = 2'd1;
    localparam logic [1:0] CFG_THRESH = 2'd2;
    localparam logic [1:0] CFG_MARGIN = 2'd3;

    typedef struct packed {
        logic [DEG_W-1:0] deg;
        logic [Y_W-1:0]   y;
        logic [X_W-1:0]   x;
        logic [LM_W-1:0]  lm;
    } t_node;

endpackage

`default_nettype wire

>>> rtl/ggrs_dist.sv
// ----------------------------------------------------------------------------
// ggrs_dist: squared distance unit
// Registers dx*dx and dy*dy, then sums them for the compare stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ggrs_dist
    import ggrs_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic [X_W-1:0]    i_x,
    input  wire logic [Y_W-1:0]    i_y,
    input  wire logic [X_W-1:0]    i_ex,
    input  wire logic [Y_W-1:0]    i_ey,
    output logic      [DIST_W-1:0] o_dist
);

    logic signed [X_W:0] dx;
    logic signed [Y_W:0] dy;
    logic [X_W-1:0]      adx;
    logic [Y_W-1:0]      ady;
    logic [2*X_W-1:0]    r_sqx;
    logic [2*Y_W-1:0]    r_sqy;

    assign dx = $signed({1'b0, i_x}) - $signed({1'b0, i_ex});
    assign dy = $signed({1'b0, i_y}) - $signed({1'b0, i_ey});

    // take magnitudes so the squares keep their full width
    assign adx = dx[X_W] ? X_W'(-dx) : dx[X_W-1:0];
    assign ady = dy[Y_W] ? Y_W'(-dy) : dy[Y_W-1:0];

    // register the squares
    always_ff @(posedge i_clk) begin
        r_sqx <= (2*X_W)'(adx) * (2*X_W)'(adx);
        r_sqy <= (2*Y_W)'(ady) * (2*Y_W)'(ady);
    end

    assign o_dist = DIST_W'(r_sqx) + DIST_W'(r_sqy);

endmodule

`default_nettype wire

>>> rtl/greedy_graph_route_search_core.sv
// ----------------------------------------------------------------------------
// greedy_graph_route_search_core: greedy best-first route search on a graph
// Node and neighbor tables in memory, walk with backtracking, path streamed out.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: tuser carries the request kind (node load, neighbor load,
//   route query), tdata the payload fields. Loads give no transaction on the
//   master side. A query yields one transaction per path
//   node (tuser = status, tlast on the final one) or a single error result.
//   Config channel writes the excluded places, prune threshold and margin;
//   it is always ready.
// Sequence:
//   A query first scans every node of the table. Each forward walk step
//   makes two passes over the current node's neighbor list; each node
//   popped while backtracking takes one more pass. Output goes out one
//   path node at a time. One item is worked on at a time and tready is
//   low until its last result is taken.
// Reset: config registers return to their defaults; table contents are kept
//   undefined until loaded. A stalled receiver holds the output register and
//   the search sequencer waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module greedy_graph_route_search_core
    import ggrs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // [5:0] node_index, [13:6] landmark_id, [24:14] node_x, [34:25] node_y,
    // [38:35] neighbor_count, [41:39] neighbor_slot, [47:42] neighbor_index,
    // [55:48] start_place, [63:56] end_place, [74:64] start_place_x,
    // [85:75] end_place_x, [87:86] zero
    input  wire logic [87:0] i_s_tdata,
    // [1:0] req_type
    input  wire logic [1:0]  i_s_tuser,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // [5:0] path_node, [7:6] zero
    output logic      [7:0]  o_m_tdata,
    output logic             o_m_tlast,
    // [1:0] status
    output logic      [1:0]  o_m_tuser,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [10:0] i_cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE, S_SC_ADDR, S_SC_DATA, S_SC_END, S_NE_RD, S_NE_DATA,
        S_W_CHECK, S_W_LM, S_E_START, S_E_DEG, S_E_NB, S_E_SQ, S_E_CMP,
        S_R_HAS, S_R_PICK, S_R_BACK, S_B_WAIT, S_O_RD, S_O_LOAD, S_O_WAIT
    } t_state;

    // input field views
    logic [NODE_W-1:0] in_node;
    logic [LM_W-1:0]   in_lm;
    logic [X_W-1:0]    in_x;
    logic [Y_W-1:0]    in_y;
    logic [DEG_W-1:0]  in_cnt;
    logic [SLOT_W-1:0] in_slot;
    logic [NODE_W-1:0] in_nbr;
    logic [LM_W-1:0]   in_sp;
    logic [LM_W-1:0]   in_ep;
    logic [X_W-1:0]    in_sx;
    logic [X_W-1:0]    in_ex;

    assign in_node = i_s_tdata[5:0];
    assign in_lm   = i_s_tdata[13:6];
    assign in_x    = i_s_tdata[24:14];
    assign in_y    = i_s_tdata[34:25];
    assign in_cnt  = i_s_tdata[38:35];
    assign in_slot = i_s_tdata[41:39];
    assign in_nbr  = i_s_tdata[47:42];
    assign in_sp   = i_s_tdata[55:48];
    assign in_ep   = i_s_tdata[63:56];
    assign in_sx   = i_s_tdata[74:64];
    assign in_ex   = i_s_tdata[85:75];

    // memories
    t_node             node_mem  [MAX_NODES];
    logic [NODE_W-1:0] nbr_mem   [MAX_NODES*MAX_DEGREE];
    logic              blk_mem   [MAX_NODES];
    logic [NODE_W-1:0] stk_mem   [MAX_NODES];
    t_node             r_node_q;
    logic [NODE_W-1:0] r_nbr_q;
    logic              r_blk_q;
    logic [NODE_W-1:0] r_stk_q;

    // config registers
    logic [LM_W-1:0] r_excl_a, r_excl_b;
    logic [X_W-1:0]  r_thresh, r_margin;

    // sequencer registers
    t_state              r_state, r_ret;
    logic [LM_W-1:0]     r_sp, r_ep;
    logic                r_prune;
    logic signed [12:0]  r_lo, r_hi;
    logic [NODE_W-1:0]   r_i, r_ns, r_ne, r_cur, r_s;
    logic                r_fs, r_fe;
    logic [X_W-1:0]      r_ex_n;
    logic [Y_W-1:0]      r_ey_n;
    logic [DEPTH_W-1:0]  r_depth, r_o_i;
    logic [GUARD_W-1:0]  r_guard;
    logic [NODE_W-1:0]   r_e_node, r_e_n, r_e_pick;
    logic [DEG_W-1:0]    r_e_deg, r_e_k;
    logic                r_e_open, r_e_blk;
    logic [BEST_W-1:0]   r_e_best;
    logic                r_out_valid, r_out_last;
    logic [NODE_W-1:0]   r_out_node;
    logic [1:0]          r_out_status;

    logic                        in_acc, out_acc;
    logic [NODE_W-1:0]           node_ra, blk_ra, stk_ra, blk_wa, stk_wa;
    logic [NODE_W+SLOT_W-1:0]    nbr_ra;
    logic                        blk_we, blk_wd, stk_we;
    logic [DEG_W-1:0]            k_next;
    logic [DIST_W-1:0]           sq_dist;
    logic                        x_out;
    logic signed [12:0]          sx13, ex13, m13;

    assign in_acc      = i_s_tvalid && o_s_tready;
    assign out_acc     = r_out_valid && i_m_tready;
    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {2'b00, r_out_node};
    assign o_m_tlast   = r_out_last;
    assign o_m_tuser   = r_out_status;
    assign k_next      = r_e_k + DEG_W'(1);

    assign sx13 = $signed({2'b00, in_sx});
    assign ex13 = $signed({2'b00, in_ex});
    assign m13  = $signed({2'b00, r_margin});
    assign x_out = ($signed({2'b00, r_node_q.x}) < r_lo)
                || ($signed({2'b00, r_node_q.x}) > r_hi);

    ggrs_dist u_dist (
        .i_clk  (i_clk),
        .i_x    (r_node_q.x),
        .i_y    (r_node_q.y),
        .i_ex   (r_ex_n),
        .i_ey   (r_ey_n),
        .o_dist (sq_dist)
    );

    // select memory addresses and write strobes
    always_comb begin
        node_ra = r_cur;
        nbr_ra  = {r_e_node, r_e_k[SLOT_W-1:0]};
        blk_ra  = r_nbr_q;
        stk_ra  = r_o_i[NODE_W-1:0];
        blk_we  = 1'b0;
        blk_wa  = r_cur;
        blk_wd  = 1'b1;
        stk_we  = 1'b0;
        stk_wa  = r_depth[NODE_W-1:0];
        case (r_state)
            S_SC_ADDR: node_ra = r_i;
            S_SC_DATA: begin
                blk_we = 1'b1;
                blk_wa = r_i;
                blk_wd = r_prune && x_out;
            end
            S_NE_RD:   node_ra = r_ne;
            S_E_START: node_ra = r_e_node;
            S_E_DEG:   nbr_ra  = {r_e_node, {SLOT_W{1'b0}}};
            S_E_NB:    node_ra = r_nbr_q;
            S_E_CMP:   nbr_ra  = {r_e_node, k_next[SLOT_W-1:0]};
            S_R_HAS: begin
                blk_we = 1'b1;
                stk_we = r_e_open && (r_depth < DEPTH_W'(MAX_NODES));
            end
            S_R_BACK:  stk_ra = NODE_W'(r_depth - DEPTH_W'(2));
            default:   node_ra = r_cur;
        endcase
    end

    // node table: load port and one read port
    always_ff @(posedge i_clk) begin
        if (in_acc && i_s_tuser == REQ_NODE) begin
            node_mem[in_node] <= '{deg: (in_cnt > DEG_MAX) ? DEG_MAX : in_cnt,
                                   y: in_y, x: in_x, lm: in_lm};
        end
        r_node_q <= node_mem[node_ra];
    end

    // neighbor table
    always_ff @(posedge i_clk) begin
        if (in_acc && i_s_tuser == REQ_NBR) begin
            nbr_mem[{in_node, in_slot}] <= in_nbr;
        end
        r_nbr_q <= nbr_mem[nbr_ra];
    end

    // blocked marks
    always_ff @(posedge i_clk) begin
        if (blk_we) begin
            blk_mem[blk_wa] <= blk_wd;
        end
        r_blk_q <= blk_mem[blk_ra];
    end

    // path stack
    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            stk_mem[stk_wa] <= r_cur;
        end
        r_stk_q <= stk_mem[stk_ra];
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_excl_a <= 8'd16;
            r_excl_b <= 8'd36;
            r_thresh <= 11'd600;
            r_margin <= 11'd80;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_EXCL_A: r_excl_a <= i_cfg_data[LM_W-1:0];
                CFG_EXCL_B: r_excl_b <= i_cfg_data[LM_W-1:0];
                CFG_THRESH: r_thresh <= i_cfg_data;
                CFG_MARGIN: r_margin <= i_cfg_data;
                default:    r_margin <= r_margin;
            endcase
        end
    end

    // search sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc && i_s_tuser == REQ_ROUTE) begin
                        r_sp    <= in_sp;
                        r_ep    <= in_ep;
                        r_prune <= !(in_sx < r_thresh || in_ex < r_thresh);
                        r_lo    <= ((in_sx < in_ex) ? sx13 : ex13) - m13;
                        r_hi    <= ((in_sx < in_ex) ? ex13 : sx13) + m13;
                        r_i     <= '0;
                        r_fs    <= 1'b0;
                        r_fe    <= 1'b0;
                        if (in_sp == r_excl_a || in_sp == r_excl_b ||
                            in_ep == r_excl_a || in_ep == r_excl_b) begin
                            r_out_node   <= '0;
                            r_out_last   <= 1'b1;
                            r_out_status <= ST_REFUSED;
                            r_out_valid  <= 1'b1;
                            r_state      <= S_O_WAIT;
                        end else begin
                            r_state <= S_SC_ADDR;
                        end
                    end
                end
                S_SC_ADDR: r_state <= S_SC_DATA;
                S_SC_DATA: begin
                    // mark pruned nodes and find the last tagged start and end
                    if (r_node_q.lm == r_sp) begin
                        r_ns <= r_i;
                        r_fs <= 1'b1;
                    end else if (r_node_q.lm == r_ep) begin
                        r_ne <= r_i;
                        r_fe <= 1'b1;
                    end
                    r_i     <= r_i + NODE_W'(1);
                    r_state <= (r_i == NODE_W'(MAX_NODES - 1)) ? S_SC_END : S_SC_ADDR;
                end
                S_SC_END: begin
                    if (!r_fs || (!r_fe && r_ep != r_sp)) begin
                        r_out_node   <= '0;
                        r_out_last   <= 1'b1;
                        r_out_status <= ST_NOTFOUND;
                        r_out_valid  <= 1'b1;
                        r_state      <= S_O_WAIT;
                    end else begin
                        if (!r_fe) begin
                            r_ne <= r_ns;
                        end
                        r_state <= S_NE_RD;
                    end
                end
                S_NE_RD: r_state <= S_NE_DATA;
                S_NE_DATA: begin
                    r_ex_n  <= r_node_q.x;
                    r_ey_n  <= r_node_q.y;
                    r_depth <= '0;
                    r_cur   <= r_ns;
                    r_s     <= r_ns;
                    r_guard <= '0;
                    r_state <= S_W_CHECK;
                end
                S_W_CHECK: r_state <= S_W_LM;
                S_W_LM: begin
                    if (r_node_q.lm == r_ep) begin
                        r_o_i   <= '0;
                        r_state <= S_O_RD;
                    end else if (r_guard + GUARD_W'(1) > GUARD_LIMIT) begin
                        r_out_node   <= '0;
                        r_out_last   <= 1'b1;
                        r_out_status <= ST_NOROUTE;
                        r_out_valid  <= 1'b1;
                        r_state      <= S_O_WAIT;
                    end else begin
                        r_guard  <= r_guard + GUARD_W'(1);
                        r_e_node <= r_cur;
                        r_ret    <= S_R_HAS;
                        r_state  <= S_E_START;
                    end
                end
                // neighbor evaluation: open flag and nearest open neighbor
                S_E_START: begin
                    r_e_open <= 1'b0;
                    r_e_best <= FAR_DISTANCE;
                    r_e_pick <= r_cur;
                    r_e_k    <= '0;
                    r_state  <= S_E_DEG;
                end
                S_E_DEG: begin
                    r_e_deg <= r_node_q.deg;
                    r_state <= (r_node_q.deg == '0) ? r_ret : S_E_NB;
                end
                S_E_NB: begin
                    r_e_n   <= r_nbr_q;
                    r_state <= S_E_SQ;
                end
                S_E_SQ: begin
                    r_e_blk <= r_blk_q;
                    r_state <= S_E_CMP;
                end
                S_E_CMP: begin
                    if (!r_e_blk) begin
                        r_e_open <= 1'b1;
                        if (BEST_W'(sq_dist) <= r_e_best) begin
                            r_e_best <= BEST_W'(sq_dist);
                            r_e_pick <= r_e_n;
                        end
                    end
                    r_e_k   <= k_next;
                    r_state <= (k_next == r_e_deg) ? r_ret : S_E_NB;
                end
                S_R_HAS: begin
                    if (r_e_open) begin
                        if (r_depth >= DEPTH_W'(MAX_NODES)) begin
                            r_out_node   <= '0;
                            r_out_last   <= 1'b1;
                            r_out_status <= ST_NOROUTE;
                            r_out_valid  <= 1'b1;
                            r_state      <= S_O_WAIT;
                        end else begin
                            r_depth  <= r_depth + DEPTH_W'(1);
                            r_s      <= r_cur;
                            r_e_node <= r_cur;
                            r_ret    <= S_R_PICK;
                            r_state  <= S_E_START;
                        end
                    end else begin
                        r_e_node <= r_s;
                        r_ret    <= S_R_BACK;
                        r_state  <= S_E_START;
                    end
                end
                S_R_PICK: begin
                    r_cur   <= r_e_pick;
                    r_state <= S_W_CHECK;
                end
                S_R_BACK: begin
                    if (r_e_open) begin
                        r_cur   <= r_e_pick;
                        r_state <= S_W_CHECK;
                    end else if (r_depth <= DEPTH_W'(1)) begin
                        r_out_node   <= '0;
                        r_out_last   <= 1'b1;
                        r_out_status <= ST_NOROUTE;
                        r_out_valid  <= 1'b1;
                        r_state      <= S_O_WAIT;
                    end else begin
                        r_depth <= r_depth - DEPTH_W'(1);
                        r_state <= S_B_WAIT;
                    end
                end
                S_B_WAIT: begin
                    r_s      <= r_stk_q;
                    r_e_node <= r_stk_q;
                    r_ret    <= S_R_BACK;
                    r_state  <= S_E_START;
                end
                // stream the path out of the stack, then the final node
                S_O_RD: begin
                    if (r_o_i < r_depth) begin
                        r_state <= S_O_LOAD;
                    end else begin
                        r_out_node   <= r_cur;
                        r_out_last   <= 1'b1;
                        r_out_status <= ST_OK;
                        r_out_valid  <= 1'b1;
                        r_state      <= S_O_WAIT;
                    end
                end
                S_O_LOAD: begin
                    r_out_node   <= r_stk_q;
                    r_out_last   <= 1'b0;
                    r_out_status <= ST_OK;
                    r_out_valid  <= 1'b1;
                    r_state      <= S_O_WAIT;
                end
                S_O_WAIT: begin
                    if (out_acc) begin
                        r_out_valid <= 1'b0;
                        r_o_i       <= r_o_i + DEPTH_W'(1);
                        r_state     <= r_out_last ? S_IDLE : S_O_RD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire
